// File: src/mrg_pkg.sv
// ----------------------------------------------------------------------------
// mrg_pkg
// Shared types and constants for the merge sorter: sizes, controller states,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mrg_pkg;

  localparam int MAX_ELEMS = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int CNT_W     = IDX_W + 1;
  // Positions within a pass reach lo + 2 * width, which never passes MAX_ELEMS.
  localparam int POS_W     = IDX_W + 2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS,
    ST_RUN,
    ST_FA,
    ST_FB,
    ST_FW,
    ST_MERGE,
    ST_REFILL,
    ST_ORD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_NEXT,
    RD_OUT
  } rd_sel_t;

  typedef struct packed {
    logic    load;        // input beat accepted
    logic    pass_first;  // start of sorting: width 1, source is the element store
    logic    pass_start;  // lo back to zero
    logic    pass_end;    // double width, swap stores
    logic    run_init;    // latch run bounds and heads' indices
    logic    run_next;    // lo advances by two widths
    rd_sel_t rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    cap_refill;
    logic    merge;       // write one merged element
    logic    out_init;
    logic    out_next;
    logic    clear;       // end of set
  } cmd_t;

  typedef struct packed {
    logic w_ge_n;
    logic lo_ge_n;
    logic run_last;
    logic out_last;
  } sts_t;

endpackage

// File: src/mrg_ram.sv
// ----------------------------------------------------------------------------
// mrg_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/mrg_ctrl.sv
// ----------------------------------------------------------------------------
// mrg_ctrl
// Controller of the merge sorter: sequences loading, the merge passes and
// the draining of the sorted set.
// ----------------------------------------------------------------------------
module mrg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tlast,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  mrg_pkg::sts_t sts,
  output mrg_pkg::cmd_t cmd
);

  import mrg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_OUT;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast) begin
            cmd.pass_first = 1'b1;
            state_next     = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        if (sts.w_ge_n) begin
          cmd.out_init = 1'b1;
          state_next   = ST_ORD;
        end else begin
          cmd.pass_start = 1'b1;
          state_next     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.lo_ge_n) begin
          cmd.pass_end = 1'b1;
          state_next   = ST_PASS;
        end else begin
          cmd.run_init = 1'b1;
          state_next   = ST_FA;
        end
      end
      ST_FA: begin
        cmd.rd_sel = RD_A;
        state_next = ST_FB;
      end
      ST_FB: begin
        cmd.rd_sel = RD_B;
        cmd.cap_a  = 1'b1;
        state_next = ST_FW;
      end
      ST_FW: begin
        cmd.cap_b  = 1'b1;
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge  = 1'b1;
        cmd.rd_sel = RD_NEXT;
        if (sts.run_last) begin
          cmd.run_next = 1'b1;
          state_next   = ST_RUN;
        end else begin
          state_next = ST_REFILL;
        end
      end
      ST_REFILL: begin
        cmd.cap_refill = 1'b1;
        state_next     = ST_MERGE;
      end
      ST_ORD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (sts.out_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end else begin
            cmd.out_next = 1'b1;
            state_next   = ST_ORD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// File: src/mrg_dp.sv
// ----------------------------------------------------------------------------
// mrg_dp
// Datapath of the merge sorter: element and scratch stores, run indices,
// the two run heads with their comparator, and the result fields.
// ----------------------------------------------------------------------------
module mrg_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  mrg_pkg::cmd_t               cmd,
  output mrg_pkg::sts_t               sts,
  input  logic [mrg_pkg::DATA_W-1:0]  in_value,
  output logic [mrg_pkg::DATA_W-1:0]  out_value,
  output logic                        out_final,
  output logic                        out_overflow
);

  import mrg_pkg::*;

  logic [CNT_W-1:0]         count;
  logic                     dropped;
  logic [POS_W-1:0]         width;
  logic [POS_W-1:0]         lo;
  logic [POS_W-1:0]         mid;
  logic [POS_W-1:0]         hi;
  logic [POS_W-1:0]         a;
  logic [POS_W-1:0]         b;
  logic [POS_W-1:0]         k;
  logic                     src_sel;   // 0: sorted data sits in the element store
  logic                     refill_a;
  logic signed [DATA_W-1:0] head_a;
  logic signed [DATA_W-1:0] head_b;

  logic [POS_W-1:0]  n_ext;
  logic [POS_W-1:0]  mid_sum;
  logic [POS_W-1:0]  hi_sum;
  logic [POS_W-1:0]  mid_calc;
  logic [POS_W-1:0]  hi_calc;
  logic [POS_W-1:0]  rd_pos;
  logic              full;
  logic              take_a;
  logic              load_wr;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;
  logic [DATA_W-1:0] rdata;

  assign n_ext    = POS_W'(count);
  assign full     = (count == CNT_W'(MAX_ELEMS));
  assign load_wr  = cmd.load && !full;
  assign mid_sum  = lo + width;
  assign hi_sum   = lo + (width << 1);
  assign mid_calc = (mid_sum > n_ext) ? n_ext : mid_sum;
  assign hi_calc  = (hi_sum > n_ext) ? n_ext : hi_sum;

  // Left run wins ties, which keeps the sort stable.
  assign take_a = (a < mid) && ((b >= hi) || (head_a <= head_b));

  assign sts.w_ge_n   = (width >= n_ext);
  assign sts.lo_ge_n  = (lo >= n_ext);
  assign sts.run_last = ((k + POS_W'(1)) == hi);
  assign sts.out_last = ((k + POS_W'(1)) == n_ext);

  always_comb begin
    case (cmd.rd_sel)
      RD_A:    rd_pos = a;
      RD_B:    rd_pos = b;
      RD_NEXT: rd_pos = take_a ? (a + POS_W'(1)) : (b + POS_W'(1));
      RD_OUT:  rd_pos = k;
      default: rd_pos = k;
    endcase
  end

  assign raddr = rd_pos[IDX_W-1:0];
  assign waddr = cmd.merge ? k[IDX_W-1:0] : count[IDX_W-1:0];
  assign wdata = cmd.merge ? (take_a ? head_a : head_b) : in_value;
  assign rdata = src_sel ? rdata_b : rdata_a;

  mrg_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ELEMS)
  ) u_elem_ram (
    .clk   (clk),
    .we    (load_wr || (cmd.merge && src_sel)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  mrg_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ELEMS)
  ) u_scratch_ram (
    .clk   (clk),
    .we    (cmd.merge && !src_sel),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.clear) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_first) begin
      width   <= POS_W'(1);
      src_sel <= 1'b0;
    end
    if (cmd.pass_end) begin
      width   <= width << 1;
      src_sel <= !src_sel;
    end
    if (cmd.pass_start) begin
      lo <= '0;
    end
    if (cmd.run_next) begin
      lo <= hi_sum;
    end
    if (cmd.run_init) begin
      mid <= mid_calc;
      hi  <= hi_calc;
      a   <= lo;
      b   <= mid_calc;
      k   <= lo;
    end
    if (cmd.cap_a) begin
      head_a <= rdata;
    end
    if (cmd.cap_b) begin
      head_b <= rdata;
    end
    if (cmd.merge) begin
      k        <= k + POS_W'(1);
      refill_a <= take_a;
      if (take_a) begin
        a <= a + POS_W'(1);
      end else begin
        b <= b + POS_W'(1);
      end
    end
    if (cmd.cap_refill) begin
      if (refill_a) begin
        head_a <= rdata;
      end else begin
        head_b <= rdata;
      end
    end
    if (cmd.out_init) begin
      k <= '0;
    end
    if (cmd.out_next) begin
      k <= k + POS_W'(1);
    end
  end

  assign out_value    = rdata;
  assign out_final    = sts.out_last;
  assign out_overflow = dropped;

endmodule

// File: src/merge_sorter.sv
// ----------------------------------------------------------------------------
// merge_sorter
// Stable ascending sort of a set of signed 32-bit values, streamed in and out.
// ----------------------------------------------------------------------------
// Values are loaded one beat per cycle into a 64-entry element store; the beat
// with tlast set closes the set. Beats beyond 64 are dropped and every result
// of that set then carries the overflow flag in m_tuser. Once a set is closed
// the block stops taking input and sorts it with bottom-up merge passes that
// ping-pong between the element store and a scratch store of the same size,
// each with one write port and one registered read port. There are
// ceil(log2(n)) passes for a set of n values. Each store has a single read
// port, so every merged element is compared and written, then the consumed
// run head is refilled, except for the last element of a run, which needs no
// refill. Each run first picks its bounds and then fetches its two heads one
// after the other. Once the passes are done the results are drained, each
// read from the store before it is offered, so a new result is not offered
// right after one is taken; the last one is marked with m_tlast. Equal values
// leave in their arrival order. After the final result beat the block is
// ready for the next set at once. A full set of 64 values takes six passes.
// ----------------------------------------------------------------------------
module merge_sorter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] sorted_value
  output logic        m_tlast,
  output logic        m_tuser     // [0] overflow
);

  import mrg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns both handshakes; the datapath only follows commands.
  mrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Results come straight from the registered read port of the store holding
  // the sorted set; the address is held while a beat is stalled.
  mrg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (s_tdata),
    .out_value    (m_tdata),
    .out_final    (m_tlast),
    .out_overflow (m_tuser)
  );

endmodule

// File: tb/tb_merge_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_merge_sorter
// Self-checking bench for the streaming merge sorter.
// ----------------------------------------------------------------------------
// A queue of beats is built up front: a few hand-picked sets (single values,
// the signed extremes, duplicates, a set already in order), then sets with
// random content. Most are short, a few fill the store exactly, and some run
// past it so that beats are dropped. Every accepted beat goes into a local
// copy of the set. On the closing beat that copy is sorted and the results
// are queued. The sender works in bursts, and the receiver stalls on a
// pattern of its own, with one long hold-off. Each result beat is compared
// with the oldest queued result.
// ----------------------------------------------------------------------------
module tb_merge_sorter;
  import mrg_pkg::MAX_ELEMS;

  typedef struct {
    logic [31:0] value;
    logic        last;
    bit          wait_drain;  // hold this beat back until all results are in
  } in_beat_t;

  typedef struct {
    logic [31:0] sorted_value;
    logic        final_res;
    logic        overflow;
  } sorted_beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] sorted_value
  logic        m_tlast;
  logic        m_tuser;        // [0] overflow

  in_beat_t     pend_q[$];
  sorted_beat_t sorted_due[$];

  // Local copy of the set being loaded.
  logic [31:0] held_vals [MAX_ELEMS];
  int          held_cnt = 0;
  bit          set_dropped = 1'b0;

  int errors = 0;
  int results_seen = 0;
  int gap_left = 0;
  int burst_left = 4;
  int rx_mode = 0;
  int rx_span = 0;
  int long_hold = 0;
  bit hold_done = 1'b0;
  int item_total = 0;

  merge_sorter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Store one accepted beat; on the closing beat sort the set and queue its
  // results. Insertion sort only moves strictly greater values, so equal
  // values keep their arrival order.
  task automatic absorb_beat(input logic [31:0] value, input logic last);
    logic signed [31:0] ord [MAX_ELEMS];
    logic signed [31:0] key;
    sorted_beat_t       res;
    int                 i;
    int                 j;
    if (held_cnt < MAX_ELEMS) begin
      held_vals[held_cnt] = value;
      held_cnt++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      for (i = 0; i < held_cnt; i++) ord[i] = held_vals[i];
      for (i = 1; i < held_cnt; i++) begin
        key = ord[i];
        j = i - 1;
        while (j >= 0 && ord[j] > key) begin
          ord[j + 1] = ord[j];
          j--;
        end
        ord[j + 1] = key;
      end
      for (i = 0; i < held_cnt; i++) begin
        res.sorted_value = ord[i];
        res.final_res    = (i == held_cnt - 1);
        res.overflow     = set_dropped;
        sorted_due.push_back(res);
      end
      held_cnt = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic push_item(input logic [31:0] value, input logic last, input bit drain);
    in_beat_t b;
    b.value = value;
    b.last = last;
    b.wait_drain = drain;
    pend_q.push_back(b);
    item_total++;
  endtask

  function automatic logic [31:0] pick_value(input int style);
    logic [31:0] v;
    case (style)
      0: v = $urandom;
      1: v = $urandom_range(0, 8) - 4;  // narrow range, many duplicates
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic queue_set(input int n, input bit drain);
    int style;
    int k;
    style = $urandom_range(0, 2);
    for (k = 0; k < n; k++) push_item(pick_value(style), k == n - 1, drain && k == 0);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin : sender
    in_beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_beat(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pend_q.size() != 0 &&
                     (!pend_q[0].wait_drain || sorted_due.size() == 0)) begin
          nxt = pend_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.value;
          s_tlast  <= nxt.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: changes stall mode every so often; one long hold-off after the
  // first few dozen results, while the sender keeps offering the next set.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 30) begin
      hold_done = 1'b1;
      long_hold = 400;
      m_tready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_span = $urandom_range(20, 80);
      end else begin
        rx_span--;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin : result_check
    sorted_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (sorted_due.size() == 0) begin
        $error("unexpected result beat: sorted_value %0d", $signed(m_tdata));
        errors++;
      end else begin
        want = sorted_due.pop_front();
        if (m_tdata !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d",
                 $signed(want.sorted_value), $signed(m_tdata));
          errors++;
        end
        if (m_tlast !== want.final_res) begin
          $error("final_res: expected %0b, got %0b", want.final_res, m_tlast);
          errors++;
        end
        if (m_tuser !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    // Single values, the signed extremes, a pair in reverse order.
    push_item(32'h0000_0000, 1'b1, 1'b0);
    push_item(32'h8000_0000, 1'b1, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_item(32'h8000_0000, 1'b1, 1'b0);
    // Duplicates mixed with extremes; equal values must keep their order.
    push_item(32'd5, 1'b0, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_item(32'd5, 1'b0, 1'b0);
    push_item(32'd0, 1'b0, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    push_item(32'd5, 1'b0, 1'b0);
    push_item(32'd1, 1'b1, 1'b0);
    // A set already in ascending order, sent after the previous ones drain.
    push_item(-32'sd3, 1'b0, 1'b1);
    push_item(-32'sd2, 1'b0, 1'b0);
    push_item(-32'sd1, 1'b0, 1'b0);
    push_item(32'd0, 1'b0, 1'b0);
    push_item(32'd1, 1'b0, 1'b0);
    push_item(32'd2, 1'b1, 1'b0);

    // A set that overruns the store (the closing beat itself is dropped),
    // and one that fills it exactly.
    queue_set(MAX_ELEMS + 3, 1'b1);
    queue_set(MAX_ELEMS, 1'b0);
    while (item_total < 220) begin
      if ($urandom_range(0, 14) == 0)
        queue_set($urandom_range(MAX_ELEMS - 4, MAX_ELEMS + 6), $urandom_range(0, 7) == 0);
      else
        queue_set($urandom_range(1, 12), $urandom_range(0, 7) == 0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || s_tvalid || sorted_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("** merge_sorter: PASSED **");
    end else begin
      $display("** merge_sorter: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** merge_sorter: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
src/mrg_pkg.sv
src/mrg_ram.sv
src/mrg_ctrl.sv
src/mrg_dp.sv
src/merge_sorter.sv
tb/tb_merge_sorter.sv
